FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL, included by gbci_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at each rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/gbci_pkg.sv
// ----------------------------------------------------------------------------
// gbci_pkg
// Widths, constants and item types for the gyro calibrate/integrate block.
// ----------------------------------------------------------------------------
package gbci_pkg;

    // Number of samples averaged for the bias estimate (1 to 1023)
    localparam int CAL_SAMPLES = 1000;

    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 17;
    localparam int ANGLE_W = 40;
    localparam int SUM_W   = 27;
    localparam int CNT_W   = 10;
    localparam int AXES    = 3;

    // Command codes carried on the cmd field
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Bias divider: |sum| * floor(2^DIV_SHIFT / CAL_SAMPLES), then one fix-up step
    localparam int ABS_W      = SUM_W - 1;
    localparam int DIV_SHIFT  = ABS_W;
    localparam int RECIP_W    = DIV_SHIFT + 1;
    localparam longint DIV_RECIP = (64'd1 << DIV_SHIFT) / CAL_SAMPLES;
    localparam int PROD_W     = ABS_W + RECIP_W;
    localparam int REM_W      = ABS_W + CNT_W;

    // Queue between front and back (depth is a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef logic signed [RAW_W-1:0]   t_raw;
    typedef logic signed [RATE_W-1:0]  t_rate;
    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // One classified, assembled word
    typedef struct packed {
        logic restart;
        t_raw raw_x;
        t_raw raw_y;
        t_raw raw_z;
    } t_item;

endpackage

FILE: src/gbci_front.sv
// ----------------------------------------------------------------------------
// gbci_front
// Input stage: accept a word, classify it and assemble the axis rates.
// ----------------------------------------------------------------------------
module gbci_front import gbci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_x_lo,
    input  logic [BYTE_W-1:0] i_x_hi,
    input  logic [BYTE_W-1:0] i_y_lo,
    input  logic [BYTE_W-1:0] i_y_hi,
    input  logic [BYTE_W-1:0] i_z_lo,
    input  logic [BYTE_W-1:0] i_z_hi,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output t_item             o_push_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    // Take a new word whenever the stage is empty or drains this cycle
    assign o_ready      = !r_valid || i_push_ready;
    assign w_take       = i_valid && o_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    // Hold valid until the queue takes the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Assemble little-endian axis rates
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.restart <= (i_cmd == CMD_RESTART);
            r_item.raw_x   <= t_raw'({i_x_hi, i_x_lo});
            r_item.raw_y   <= t_raw'({i_y_hi, i_y_lo});
            r_item.raw_z   <= t_raw'({i_z_hi, i_z_lo});
        end
    end

endmodule

FILE: src/gbci_queue.sv
// ----------------------------------------------------------------------------
// gbci_queue
// Short FIFO that decouples the input stage from the processing stage.
// ----------------------------------------------------------------------------
module gbci_queue import gbci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop,
    output t_item o_pop_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = r_count != (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: src/gbci_back.sv
// ----------------------------------------------------------------------------
// gbci_back
// Processing stage: bias sums, bias divide, offset correction, saturating
// angle integration and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbci_back import gbci_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_item  i_q_item,
    output logic   o_q_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_rate  o_rate_x,
    output t_rate  o_rate_y,
    output t_rate  o_rate_z,
    output t_angle o_angle_x,
    output t_angle o_angle_y,
    output t_angle o_angle_z,
    output logic   o_calibrating
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_FIX
    } t_state;

    t_state             r_state;
    logic               r_phase;
    logic [CNT_W-1:0]   r_count;
    t_sum               r_sum   [AXES];
    t_raw               r_off   [AXES];
    t_angle             r_acc   [AXES];
    logic [ABS_W-1:0]   r_q0    [AXES];
    logic               r_out_valid;
    t_rate              r_rate  [AXES];
    t_angle             r_angle [AXES];
    logic               r_cal;

    t_raw               w_raw   [AXES];
    t_rate              w_rate  [AXES];
    t_sum               n_sum   [AXES];
    t_angle             n_acc   [AXES];
    logic [ANGLE_W:0]   w_acc_sum [AXES];
    logic [ABS_W-1:0]   w_abs   [AXES];
    logic [PROD_W-1:0]  w_prod  [AXES];
    logic [REM_W-1:0]   w_qc    [AXES];
    logic [REM_W-1:0]   w_rem   [AXES];
    logic [ABS_W-1:0]   w_q     [AXES];
    t_raw               n_off   [AXES];
    logic [CNT_W-1:0]   n_count;
    logic               w_last;
    logic               w_pop;
    logic               w_sample;

    assign w_raw[0] = i_q_item.raw_x;
    assign w_raw[1] = i_q_item.raw_y;
    assign w_raw[2] = i_q_item.raw_z;

    // Pop only while running and the output register can take a result
    assign w_pop    = (r_state == ST_RUN) && i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop  = w_pop;
    assign w_sample = !i_q_item.restart;
    assign n_count  = r_count + 1'b1;
    assign w_last   = n_count == CNT_W'(CAL_SAMPLES);

    // Per-axis datapath: correction, sums, saturating add, bias divide
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_rate[i]    = RATE_W'(w_raw[i]) - RATE_W'(r_off[i]);
            n_sum[i]     = r_sum[i] + SUM_W'(w_raw[i]);
            w_acc_sum[i] = (ANGLE_W + 1)'(r_acc[i]) + (ANGLE_W + 1)'(w_rate[i]);
            if (w_acc_sum[i][ANGLE_W] != w_acc_sum[i][ANGLE_W-1]) begin
                n_acc[i] = w_acc_sum[i][ANGLE_W] ? {1'b1, {(ANGLE_W - 1){1'b0}}}
                                                 : {1'b0, {(ANGLE_W - 1){1'b1}}};
            end else begin
                n_acc[i] = w_acc_sum[i][ANGLE_W-1:0];
            end
            w_abs[i]  = r_sum[i][SUM_W-1] ? ABS_W'(-r_sum[i]) : ABS_W'(r_sum[i]);
            w_prod[i] = PROD_W'(w_abs[i]) * PROD_W'(DIV_RECIP);
            w_qc[i]   = REM_W'(r_q0[i]) * REM_W'(CAL_SAMPLES);
            w_rem[i]  = REM_W'(w_abs[i]) - w_qc[i];
            w_q[i]    = r_q0[i] + ABS_W'(w_rem[i] >= REM_W'(CAL_SAMPLES));
            n_off[i]  = r_sum[i][SUM_W-1] ? -w_q[i][RAW_W-1:0] : w_q[i][RAW_W-1:0];
        end
    end

    // State, calibration bookkeeping, accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_phase     <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i] <= '0;
                r_off[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (w_pop && !w_sample) begin
                        r_phase <= 1'b1;
                        r_count <= '0;
                        for (int i = 0; i < AXES; i++) begin
                            r_sum[i] <= '0;
                        end
                    end else if (w_pop && r_phase) begin
                        for (int i = 0; i < AXES; i++) begin
                            r_sum[i] <= n_sum[i];
                        end
                        if (w_last) begin
                            r_phase <= 1'b0;
                            r_count <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_count <= n_count;
                        end
                    end else if (w_pop) begin
                        for (int i = 0; i < AXES; i++) begin
                            r_acc[i] <= n_acc[i];
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_off[i] <= n_off[i];
                    end
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // Quotient estimate from the reciprocal product
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            for (int i = 0; i < AXES; i++) begin
                r_q0[i] <= w_prod[i][DIV_SHIFT +: ABS_W];
            end
        end
    end

    // Load the result word on each pop
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cal <= w_sample && r_phase;
            for (int i = 0; i < AXES; i++) begin
                r_rate[i]  <= w_sample ? w_rate[i] : '0;
                r_angle[i] <= (w_sample && !r_phase) ? n_acc[i] : r_acc[i];
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rate_x      = r_rate[0];
    assign o_rate_y      = r_rate[1];
    assign o_rate_z      = r_rate[2];
    assign o_angle_x     = r_angle[0];
    assign o_angle_y     = r_angle[1];
    assign o_angle_z     = r_angle[2];
    assign o_calibrating = r_cal;

    `ASSERT_CLK(a_mul_then_fix, (r_state == ST_MUL) |=> (r_state == ST_FIX), "divide step skipped")
    `ASSERT_CLK(a_no_pop_in_div, (r_state != ST_RUN) |-> !o_q_pop, "pop during bias divide")
    `ASSERT_CLK(a_phase_off_in_div, (r_state != ST_RUN) |-> !r_phase, "calibrating during divide")
    `ASSERT_CLK(a_count_range, r_count < CNT_W'(CAL_SAMPLES), "calibration count overrun")

endmodule

FILE: src/gyro_bias_calibrate_integrate_top.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_top
// Gyro bias calibration and rate integration: input stage, queue, processing.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  in      | i_valid / o_ready  | i_cmd, i_x_lo .. i_z_hi
//  out     | o_valid / i_ready  | o_rate_*, o_angle_*, o_calibrating
//
//  One word per cycle unless the output stalls or the bias divide runs; results
//  pass the input, queue and output registers. After the last calibration sample
//  the divide (reciprocal multiply, then one-step fix-up) runs; nothing is popped.
//  Reset clears the calibration state, offsets and angle accumulators.
//  Either side may stall on its own; the 2-entry queue absorbs the difference.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_top import gbci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_x_lo,
    input  logic [BYTE_W-1:0] i_x_hi,
    input  logic [BYTE_W-1:0] i_y_lo,
    input  logic [BYTE_W-1:0] i_y_hi,
    input  logic [BYTE_W-1:0] i_z_lo,
    input  logic [BYTE_W-1:0] i_z_hi,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rate             o_rate_x,
    output t_rate             o_rate_y,
    output t_rate             o_rate_z,
    output t_angle            o_angle_x,
    output t_angle            o_angle_y,
    output t_angle            o_angle_z,
    output logic              o_calibrating
);

    logic  w_push_valid;
    logic  w_push_ready;
    t_item w_push_item;
    logic  w_pop_valid;
    logic  w_pop;
    t_item w_pop_item;

    gbci_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_x_lo       (i_x_lo),
        .i_x_hi       (i_x_hi),
        .i_y_lo       (i_y_lo),
        .i_y_hi       (i_y_hi),
        .i_z_lo       (i_z_lo),
        .i_z_hi       (i_z_hi),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    gbci_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_item   (w_pop_item)
    );

    gbci_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_pop_valid),
        .i_q_item      (w_pop_item),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rate_x      (o_rate_x),
        .o_rate_y      (o_rate_y),
        .o_rate_z      (o_rate_z),
        .o_angle_x     (o_angle_x),
        .o_angle_y     (o_angle_y),
        .o_angle_z     (o_angle_z),
        .o_calibrating (o_calibrating)
    );

endmodule

FILE: bench/gbci_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbci_result_checker
// Watches both channels of the gyro calibrate/integrate block, predicts each
// result word from the accepted input words and compares them field by field.
// ----------------------------------------------------------------------------
module gbci_result_checker import gbci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_x_lo,
    input  logic [BYTE_W-1:0] i_x_hi,
    input  logic [BYTE_W-1:0] i_y_lo,
    input  logic [BYTE_W-1:0] i_y_hi,
    input  logic [BYTE_W-1:0] i_z_lo,
    input  logic [BYTE_W-1:0] i_z_hi,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_rate             i_rate_x,
    input  t_rate             i_rate_y,
    input  t_rate             i_rate_z,
    input  t_angle            i_angle_x,
    input  t_angle            i_angle_y,
    input  t_angle            i_angle_z,
    input  logic              i_calibrating,
    output int                o_pending,
    output int                o_fail_count
);

    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        t_rate  rate_x;
        t_rate  rate_y;
        t_rate  rate_z;
        t_angle angle_x;
        t_angle angle_y;
        t_angle angle_z;
        logic   calibrating;
    } t_gyro_word;

    localparam longint ANGLE_HI = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam longint ANGLE_LO = -ANGLE_HI - 1;

    // Predicted block state
    logic             in_cal;
    logic [CNT_W-1:0] cal_seen;
    t_sum             axis_sum   [AXES];
    t_raw             axis_bias  [AXES];
    t_angle           axis_angle [AXES];

    t_gyro_word gyro_words_due [$];
    t_gyro_word head;
    int         fail_count = 0;

    // Advance the predicted state by one word and return the word it produces
    function automatic t_gyro_word integrate_word(input logic restart,
                                                  input t_raw rx, input t_raw ry,
                                                  input t_raw rz);
        t_wide      raw  [AXES];
        t_wide      rate [AXES];
        t_wide      acc;
        t_gyro_word w;
        int         a;
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        w = '0;
        if (restart) begin
            // Restart: drop the partial sums, keep offsets and angles
            in_cal   = 1'b1;
            cal_seen = '0;
            for (a = 0; a < AXES; a++) begin
                axis_sum[a] = '0;
                rate[a]     = '0;
            end
        end else begin
            for (a = 0; a < AXES; a++) begin
                rate[a] = raw[a] - axis_bias[a];
            end
            if (in_cal) begin
                // Calibration sample: accumulate, load offsets on the last one
                w.calibrating = 1'b1;
                for (a = 0; a < AXES; a++) begin
                    axis_sum[a] = axis_sum[a] + t_sum'(raw[a]);
                end
                cal_seen = cal_seen + 1'b1;
                if (cal_seen == CNT_W'(CAL_SAMPLES)) begin
                    // Signed divide truncates toward zero
                    for (a = 0; a < AXES; a++) begin
                        axis_bias[a] = t_raw'(t_wide'(axis_sum[a]) / CAL_SAMPLES);
                    end
                    in_cal   = 1'b0;
                    cal_seen = '0;
                end
            end else begin
                // Integrate with saturation at the 40-bit limits
                for (a = 0; a < AXES; a++) begin
                    acc = axis_angle[a] + rate[a];
                    if (acc > ANGLE_HI) acc = ANGLE_HI;
                    if (acc < ANGLE_LO) acc = ANGLE_LO;
                    axis_angle[a] = t_angle'(acc);
                end
            end
        end
        w.rate_x  = t_rate'(rate[0]);
        w.rate_y  = t_rate'(rate[1]);
        w.rate_z  = t_rate'(rate[2]);
        w.angle_x = axis_angle[0];
        w.angle_y = axis_angle[1];
        w.angle_z = axis_angle[2];
        return w;
    endfunction

    task automatic check_field(input string field, input t_wide want, input t_wide got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Predict on every accepted input word, compare on every accepted result word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_cal   = 1'b1;
            cal_seen = '0;
            for (int a = 0; a < AXES; a++) begin
                axis_sum[a]   = '0;
                axis_bias[a]  = '0;
                axis_angle[a] = '0;
            end
            gyro_words_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                gyro_words_due.push_back(integrate_word(i_cmd, {i_x_hi, i_x_lo},
                                                        {i_y_hi, i_y_lo},
                                                        {i_z_hi, i_z_lo}));
            end
            if (i_out_valid && i_out_ready) begin
                if (gyro_words_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    head = gyro_words_due.pop_front();
                    check_field("rate_x", head.rate_x, i_rate_x);
                    check_field("rate_y", head.rate_y, i_rate_y);
                    check_field("rate_z", head.rate_z, i_rate_z);
                    check_field("angle_x", head.angle_x, i_angle_x);
                    check_field("angle_y", head.angle_y, i_angle_y);
                    check_field("angle_z", head.angle_z, i_angle_z);
                    check_field("calibrating", t_wide'(head.calibrating),
                                t_wide'(i_calibrating));
                end
            end
        end
        o_pending    <= gyro_words_due.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: bench/gyro_bias_calibrate_integrate_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_top_tb
// Drives gyro sample and restart words into the block with random gaps and
// output stalls: extremes first, then a full calibration around random biases,
// integration, and restarts into partial calibrations. The checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_top_tb import gbci_pkg::*;;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_cmd   = 1'b0;
    logic [BYTE_W-1:0] i_x_lo  = '0;
    logic [BYTE_W-1:0] i_x_hi  = '0;
    logic [BYTE_W-1:0] i_y_lo  = '0;
    logic [BYTE_W-1:0] i_y_hi  = '0;
    logic [BYTE_W-1:0] i_z_lo  = '0;
    logic [BYTE_W-1:0] i_z_hi  = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_rate             o_rate_x;
    t_rate             o_rate_y;
    t_rate             o_rate_z;
    t_angle            o_angle_x;
    t_angle            o_angle_y;
    t_angle            o_angle_z;
    logic              o_calibrating;

    int   words_pending;
    int   fail_count;
    int   words_sent = 0;
    logic sender_idles = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    gyro_bias_calibrate_integrate_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_x_lo        (i_x_lo),
        .i_x_hi        (i_x_hi),
        .i_y_lo        (i_y_lo),
        .i_y_hi        (i_y_hi),
        .i_z_lo        (i_z_lo),
        .i_z_hi        (i_z_hi),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rate_x      (o_rate_x),
        .o_rate_y      (o_rate_y),
        .o_rate_z      (o_rate_z),
        .o_angle_x     (o_angle_x),
        .o_angle_y     (o_angle_y),
        .o_angle_z     (o_angle_z),
        .o_calibrating (o_calibrating)
    );

    gbci_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_cmd         (i_cmd),
        .i_x_lo        (i_x_lo),
        .i_x_hi        (i_x_hi),
        .i_y_lo        (i_y_lo),
        .i_y_hi        (i_y_hi),
        .i_z_lo        (i_z_lo),
        .i_z_hi        (i_z_hi),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_rate_x      (o_rate_x),
        .i_rate_y      (o_rate_y),
        .i_rate_z      (o_rate_z),
        .i_angle_x     (o_angle_x),
        .i_angle_y     (o_angle_y),
        .i_angle_z     (o_angle_z),
        .i_calibrating (o_calibrating),
        .o_pending     (words_pending),
        .o_fail_count  (fail_count)
    );

    // Mostly no gap or a short one, now and then a long one
    function automatic int pick_gap(input logic enable);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enable || roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One axis: noise around a bias, or now and then any 16-bit value
    function automatic logic [15:0] gen_axis(input int bias);
        int v;
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        v = bias + int'($urandom_range(0, 800)) - 400;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic cmd, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = pick_gap(sender_idles);
        words_sent++;
        if (words_sent % 50 == 0) sender_idles = ($urandom_range(0, 3) != 0);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_x_lo  <= x[7:0];
        i_x_hi  <= x[15:8];
        i_y_lo  <= y[7:0];
        i_y_hi  <= y[15:8];
        i_z_lo  <= z[7:0];
        i_z_hi  <= z[15:8];
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_sample(input int bx, input int by, input int bz);
        send_word(CMD_SAMPLE, gen_axis(bx), gen_axis(by), gen_axis(bz));
    endtask

    // Receiver: random stalls with long stretches of steady ready
    initial begin : ready_driver
        int stall;
        int run;
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                stall = 0;
                run   = $urandom_range(50, 200);
            end else begin
                stall = pick_gap(1'b1);
                run   = $urandom_range(1, 12);
            end
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            repeat (run) begin
                @(negedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int bias_x;
        int bias_y;
        int bias_z;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes and bit patterns while calibrating from reset
        send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h0001);
        send_word(CMD_SAMPLE, 16'hFFFF, 16'h0001, 16'h8000);
        send_word(CMD_SAMPLE, 16'h55AA, 16'hAA55, 16'h00FF);
        send_word(CMD_SAMPLE, 16'hAA55, 16'hFF00, 16'h55AA);
        // Restart mid-calibration; its sample bytes must be ignored
        send_word(CMD_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'h1234, 16'hEDCB, 16'h8001);
        send_word(CMD_RESTART, 16'hA5A5, 16'h5A5A, 16'h0F0F);
        send_word(CMD_RESTART, 16'h0000, 16'h0000, 16'h0000);

        // Full calibration: x biased negative, y positive, z either way,
        // so the bias divide truncates toward zero on both signs
        bias_x = -int'($urandom_range(200, 6000));
        bias_y = int'($urandom_range(200, 6000));
        bias_z = $urandom_range(0, 1) ? int'($urandom_range(0, 6000))
                                      : -int'($urandom_range(0, 6000));
        repeat (CAL_SAMPLES) send_sample(bias_x, bias_y, bias_z);

        // First words under the new offsets; extremes push the rate past 16 bits
        send_word(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_word(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000);
        send_word(CMD_SAMPLE, 16'h0000, 16'hFFFF, 16'h0001);

        // Integration; the angle clamp lies far beyond this run's reach
        repeat (480) send_sample(bias_x, bias_y, bias_z);

        // Restart from integration, then a partial calibration with old offsets
        send_word(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (240) send_sample(bias_y, bias_z, bias_x);
        send_word(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (10) send_sample(bias_x, bias_y, bias_z);

        // Drain the result words, then allow for the pipeline
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
